// ===== design/tpc_pkg.sv =====
package tpc_pkg;

    localparam int DIV_STEPS = 24;
    localparam int LANES     = 9;

    typedef struct packed {
        logic [16:0] rem;
        logic [23:0] dq;
        logic [15:0] den;
        logic        neg;
    } div_lane_t;

    typedef logic signed [15:0] q88_t;

endpackage

// ===== design/triangle_plane_coefficients.sv =====
// Plane equation of one triangle per item. Each of the nine vertex
// coordinates is divided by its vertex w, saturated to Q8.8, and the normal
// (a, b, c) and offset d are formed from the projected points. The block
// takes one triangle every clock while the output is not stalled. The
// pipeline is made of the nine restoring dividers, which retire one quotient
// bit per pipeline stage over 24 stages, followed by six arithmetic stages.
// A stall on the output holds the whole pipeline. If any w is zero,
// zero_divisor is set and all coefficients are zero.
module triangle_plane_coefficients (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // v1_x, v1_y, v1_z, v1_w, v2_x, v2_y, v2_z, v2_w, v3_x, v3_y, v3_z, v3_w
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // coef_a, coef_b, coef_c, coef_d, two zero bits
    output logic [159:0] m_tdata,
    // zero_divisor
    output logic         m_tuser
);

    localparam int NS = tpc_pkg::DIV_STEPS;
    localparam int NL = tpc_pkg::LANES;

    logic adv;

    tpc_pkg::div_lane_t div_reg  [0:NS][0:NL-1];
    tpc_pkg::div_lane_t div_next [0:NS][0:NL-1];
    logic               dvld_reg [0:NS];
    logic               dzero_reg[0:NS];

    tpc_pkg::q88_t      proj_reg [0:NL-1];
    tpc_pkg::q88_t      proj_next[0:NL-1];
    logic               pvld_reg, pzero_reg;

    logic signed [16:0] u_reg [0:2];
    logic signed [16:0] v_reg [0:2];
    tpc_pkg::q88_t      p1d_reg [0:2];
    logic               fvld_reg, fzero_reg;

    logic signed [33:0] m_reg [0:5];
    tpc_pkg::q88_t      p1m_reg [0:2];
    logic               mvld_reg, mzero_reg;

    logic signed [34:0] n_reg [0:2];
    tpc_pkg::q88_t      p1n_reg [0:2];
    logic               nvld_reg, nzero_reg;

    logic signed [50:0] e_reg [0:2];
    logic signed [34:0] ne_reg [0:2];
    logic               evld_reg, ezero_reg;

    logic signed [34:0] a_reg, b_reg, c_reg;
    logic signed [52:0] d_reg;
    logic               ovld_reg, ozero_reg;
    logic signed [52:0] d_next;

    assign adv      = !ovld_reg || m_tready;
    assign s_tready = adv;

    // load dividers with magnitudes
    generate
        for (genvar l = 0; l < NL; l++) begin : g_load
            localparam int VI = l / 3;
            localparam int CI = l % 3;
            logic [15:0] num, den;
            logic [23:0] n24;
            assign num = s_tdata[(VI*4+CI)*16 +: 16];
            assign den = s_tdata[(VI*4+3)*16 +: 16];
            assign n24 = {num, 8'h00};
            assign div_next[0][l].rem = '0;
            assign div_next[0][l].dq  = num[15] ? (~n24 + 24'd1) : n24;
            assign div_next[0][l].den = den[15] ? (~den + 16'd1) : den;
            assign div_next[0][l].neg = num[15] ^ den[15];
        end

        for (genvar s = 0; s < NS; s++) begin : g_step
            for (genvar l = 0; l < NL; l++) begin : g_lane
                logic [16:0] rs;
                logic [17:0] diff;
                assign rs   = {div_reg[s][l].rem[15:0], div_reg[s][l].dq[23]};
                assign diff = {1'b0, rs} - {2'b00, div_reg[s][l].den};
                assign div_next[s+1][l].rem = diff[17] ? rs : diff[16:0];
                assign div_next[s+1][l].dq  = {div_reg[s][l].dq[22:0], !diff[17]};
                assign div_next[s+1][l].den = div_reg[s][l].den;
                assign div_next[s+1][l].neg = div_reg[s][l].neg;
            end
        end

        for (genvar l = 0; l < NL; l++) begin : g_sat
            logic [23:0] mag;
            assign mag = div_reg[NS][l].dq;
            always_comb begin
                if (div_reg[NS][l].neg) begin
                    if (mag > 24'd32768) proj_next[l] = 16'sh8000;
                    else                 proj_next[l] = ~mag[15:0] + 16'd1;
                end else begin
                    if (mag > 24'd32767) proj_next[l] = 16'sh7fff;
                    else                 proj_next[l] = mag[15:0];
                end
            end
        end
    endgenerate

    logic [2:0] w_zero;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_zero[i] = (s_tdata[(i*4+3)*16 +: 16] == 16'h0000);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 0; s <= NS; s++) begin
                for (int l = 0; l < NL; l++) begin
                    div_reg[s][l] <= div_next[s][l];
                end
            end
            dzero_reg[0] <= |w_zero;
            for (int s = 0; s < NS; s++) begin
                dzero_reg[s+1] <= dzero_reg[s];
            end
            for (int l = 0; l < NL; l++) begin
                proj_reg[l] <= proj_next[l];
            end
            pzero_reg <= dzero_reg[NS];

            for (int c = 0; c < 3; c++) begin
                u_reg[c]   <= 17'(proj_reg[3+c]) - 17'(proj_reg[c]);
                v_reg[c]   <= 17'(proj_reg[6+c]) - 17'(proj_reg[c]);
                p1d_reg[c] <= proj_reg[c];
            end
            fzero_reg <= pzero_reg;

            m_reg[0] <= u_reg[1] * v_reg[2];
            m_reg[1] <= u_reg[2] * v_reg[1];
            m_reg[2] <= u_reg[2] * v_reg[0];
            m_reg[3] <= u_reg[0] * v_reg[2];
            m_reg[4] <= u_reg[0] * v_reg[1];
            m_reg[5] <= u_reg[1] * v_reg[0];
            p1m_reg   <= p1d_reg;
            mzero_reg <= fzero_reg;

            n_reg[0]  <= 35'(m_reg[0]) - 35'(m_reg[1]);
            n_reg[1]  <= 35'(m_reg[2]) - 35'(m_reg[3]);
            n_reg[2]  <= 35'(m_reg[4]) - 35'(m_reg[5]);
            p1n_reg   <= p1m_reg;
            nzero_reg <= mzero_reg;

            for (int c = 0; c < 3; c++) begin
                e_reg[c] <= p1n_reg[c] * n_reg[c];
            end
            ne_reg    <= n_reg;
            ezero_reg <= nzero_reg;

            // clear everything on a zero divisor
            a_reg     <= ezero_reg ? '0 : ne_reg[0];
            b_reg     <= ezero_reg ? '0 : ne_reg[1];
            c_reg     <= ezero_reg ? '0 : ne_reg[2];
            d_reg     <= ezero_reg ? '0 : d_next;
            ozero_reg <= ezero_reg;
        end
    end

    assign d_next = -(53'(e_reg[0]) + 53'(e_reg[1]) + 53'(e_reg[2]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= NS; s++) begin
                dvld_reg[s] <= 1'b0;
            end
            pvld_reg <= 1'b0;
            fvld_reg <= 1'b0;
            mvld_reg <= 1'b0;
            nvld_reg <= 1'b0;
            evld_reg <= 1'b0;
            ovld_reg <= 1'b0;
        end else if (adv) begin
            dvld_reg[0] <= s_tvalid;
            for (int s = 0; s < NS; s++) begin
                dvld_reg[s+1] <= dvld_reg[s];
            end
            pvld_reg <= dvld_reg[NS];
            fvld_reg <= pvld_reg;
            mvld_reg <= fvld_reg;
            nvld_reg <= mvld_reg;
            evld_reg <= nvld_reg;
            ovld_reg <= evld_reg;
        end
    end

    assign m_tvalid = ovld_reg;
    assign m_tuser  = ozero_reg;
    assign m_tdata  = {2'b00, d_reg, c_reg, b_reg, a_reg};

    a_zero_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero divisor result carries nonzero coefficients");

    a_hold_result : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

    a_ready_follows : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track output stall");

endmodule

// ===== tb/sv/tb_triangle_plane_coefficients.sv =====
module tb_triangle_plane_coefficients;

    typedef struct {
        logic signed [34:0] a;
        logic signed [34:0] b;
        logic signed [34:0] c;
        logic signed [52:0] d;
        logic               zdiv;
    } plane_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;
    logic         m_tuser;

    plane_t plane_q[$];
    int     err_cnt;
    int     hold_cycles;
    bit     rx_bursty;

    triangle_plane_coefficients DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint project_q88(longint num, longint den);
        longint q;
        q = (num * 256) / den;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q;
    endfunction

    function automatic plane_t plane_of(logic [191:0] tri_bits);
        plane_t r;
        longint v[12];
        longint p[3][3];
        longint ux, uy, uz, wx, wy, wz, a, b, c, d;
        for (int i = 0; i < 12; i++) v[i] = longint'($signed(tri_bits[i*16 +: 16]));
        r = '{a: '0, b: '0, c: '0, d: '0, zdiv: 1'b0};
        if (v[3] == 0 || v[7] == 0 || v[11] == 0) begin
            r.zdiv = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                p[i][k] = project_q88(v[i*4+k], v[i*4+3]);
        ux = p[1][0] - p[0][0];
        uy = p[1][1] - p[0][1];
        uz = p[1][2] - p[0][2];
        wx = p[2][0] - p[0][0];
        wy = p[2][1] - p[0][1];
        wz = p[2][2] - p[0][2];
        a = uy * wz - uz * wy;
        b = uz * wx - ux * wz;
        c = ux * wy - uy * wx;
        d = -(p[0][0] * a + p[0][1] * b + p[0][2] * c);
        r.a = a[34:0];
        r.b = b[34:0];
        r.c = c[34:0];
        r.d = d[52:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic send_triangle(logic [191:0] tri_bits, bit bursty);
        int g;
        g = bursty ? 0 : gap_len();
        repeat (g) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tri_bits;
        plane_q.push_back(plane_of(tri_bits));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [191:0] pack_tri(logic [15:0] f[12]);
        logic [191:0] t;
        for (int i = 0; i < 12; i++) t[i*16 +: 16] = f[i];
        return t;
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_w();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h0100;
            2: return 16'h8000;
            3: return 16'h7fff;
            4: return 16'($urandom_range(1, 8));
            5: return -16'($urandom_range(1, 8));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [191:0] rand_tri();
        logic [15:0] f[12];
        for (int i = 0; i < 12; i++) f[i] = (i % 4 == 3) ? rand_w() : rand_coord();
        return pack_tri(f);
    endfunction

    task automatic test_directed();
        logic [15:0] f[12];
        // unit triangle, w = 1.0
        f = '{16'h0000, 16'h0000, 16'h0000, 16'h0100,
              16'h0100, 16'h0000, 16'h0000, 16'h0100,
              16'h0000, 16'h0100, 16'h0000, 16'h0100};
        send_triangle(pack_tri(f), 0);
        // zero divisor on each vertex
        for (int k = 0; k < 3; k++) begin
            f[k*4+3] = 16'h0000;
            send_triangle(pack_tri(f), 0);
            f[k*4+3] = 16'h0100;
        end
        // degenerate: coincident and collinear
        f = '{16'h0200, 16'h0300, 16'h0400, 16'h0100,
              16'h0200, 16'h0300, 16'h0400, 16'h0100,
              16'h0400, 16'h0600, 16'h0800, 16'h0100};
        send_triangle(pack_tri(f), 0);
        // saturation both ways with tiny w
        f = '{16'h7fff, 16'h8000, 16'h7fff, 16'h0001,
              16'h8000, 16'h7fff, 16'h8000, 16'h0001,
              16'h7fff, 16'h7fff, 16'h8000, 16'hffff};
        send_triangle(pack_tri(f), 0);
        // extreme w values
        f = '{16'h8000, 16'h7fff, 16'h8000, 16'h8000,
              16'h7fff, 16'h8000, 16'h1234, 16'h7fff,
              16'h8000, 16'h8000, 16'h7fff, 16'h8000};
        send_triangle(pack_tri(f), 0);
        f = '{16'hffff, 16'h0001, 16'h0000, 16'hffff,
              16'h0001, 16'hffff, 16'hffff, 16'h0001,
              16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0};
        send_triangle(pack_tri(f), 0);
        // largest normal: projected corners at the range limits
        f = '{16'h8000, 16'h8000, 16'h8000, 16'h0100,
              16'h7fff, 16'h8000, 16'h7fff, 16'h0100,
              16'h8000, 16'h7fff, 16'h7fff, 16'h0100};
        send_triangle(pack_tri(f), 0);
        idle_sender();
    endtask

    task automatic test_random();
        for (int n = 0; n < 650; n++) send_triangle(rand_tri(), 0);
        idle_sender();
    endtask

    task automatic test_backpressure();
        rx_bursty   = 1'b1;
        hold_cycles = 120;
        for (int n = 0; n < 100; n++) send_triangle(rand_tri(), 1);
        idle_sender();
        rx_bursty = 1'b0;
    endtask

    always @(posedge aclk) begin
        plane_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (plane_q.size() == 0) begin
                $display("unexpected result at %0t", $time);
                err_cnt++;
            end else begin
                want = plane_q.pop_front();
                if ($signed(m_tdata[34:0]) !== want.a)
                    report_mismatch("coef_a", $signed(m_tdata[34:0]), want.a);
                if ($signed(m_tdata[69:35]) !== want.b)
                    report_mismatch("coef_b", $signed(m_tdata[69:35]), want.b);
                if ($signed(m_tdata[104:70]) !== want.c)
                    report_mismatch("coef_c", $signed(m_tdata[104:70]), want.c);
                if ($signed(m_tdata[157:105]) !== want.d)
                    report_mismatch("coef_d", $signed(m_tdata[157:105]), want.d);
                if (m_tuser !== want.zdiv)
                    report_mismatch("zero_divisor", m_tuser, want.zdiv);
            end
        end
    end

    initial begin
        int g;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            g = rx_bursty ? 0 : gap_len();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int wait_cnt;
        err_cnt     = 0;
        hold_cycles = 0;
        rx_bursty   = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        wait_cnt = 0;
        while (plane_q.size() != 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (40) @(posedge aclk);
        if (err_cnt == 0 && plane_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/tpc_pkg.sv
design/triangle_plane_coefficients.sv
tb/sv/tb_triangle_plane_coefficients.sv
